/* hdl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sequential list table: command and
// result payloads, opcode and status codes, controller states.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CAP_W     = 5;
    localparam int POS_W     = 4;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [WORD_W-1:0] item_value;
        logic [POS_W-1:0]         position;
    } slt_in_t;

    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] read_value;
        logic [COUNT_W-1:0]       entry_count;
    } slt_out_t;

    typedef struct packed {
        logic  shift;
        word_t feed;
    } slt_chain_ctl_t;

endpackage

/* hdl/slt_cell.sv */
// ----------------------------------------------------------------------------
// slt_cell
// One storage cell of the list ring: holds one entry and takes the entry at
// its input (its neighbor's, or the fed word at the tail) whenever the ring steps.
// ----------------------------------------------------------------------------
module slt_cell (
    input  logic          clk,
    input  logic          shift,
    input  slt_pkg::word_t din,
    output slt_pkg::word_t q
);
    import slt_pkg::*;

    word_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    assign q = data_reg;

endmodule

/* hdl/slt_ctrl.sv */
// ----------------------------------------------------------------------------
// slt_ctrl
// Sequencer for the list ring: walks one full rotation per command, picks
// the word fed into the tail cell, tracks count, capacity and the result.
// ----------------------------------------------------------------------------
module slt_ctrl #(
    parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  slt_pkg::slt_in_t       request,
    output logic                   result_valid,
    output slt_pkg::slt_out_t      result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [slt_pkg::CAP_W-1:0] cfg_data,
    input  slt_pkg::word_t         head,
    input  slt_pkg::word_t         second,
    output slt_pkg::slt_chain_ctl_t chain_ctl
);
    import slt_pkg::*;

    localparam int KW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [KW-1:0]   K_LAST    = KW'(DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    opcode_t           op_reg, op_next;
    word_t             val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              err_reg, err_next;
    logic              found_reg, found_next;
    word_t             rd_reg, rd_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              done_reg, done_next;
    slt_out_t          res_reg, res_next;

    logic              accept;
    logic              last_step;
    logic              full;
    logic              out_of_range;
    logic [CMPW-1:0]   k_cmp;
    logic [CMPW-1:0]   pos_cmp;
    logic [CMPW-1:0]   count_cmp;
    status_t           status_fin;

    assign accept    = start && (state_reg == S_IDLE);
    assign last_step = (k_reg == K_LAST);
    assign k_cmp     = CMPW'(k_reg);
    assign pos_cmp   = CMPW'(pos_reg);
    assign count_cmp = CMPW'(count_reg);

    assign full = (count_cmp >= CMPW'(cap_reg)) || (count_cmp >= DEPTH_CMP);
    assign out_of_range = (CMPW'(request.position) >= count_cmp);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (last_step)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        k_next          = k_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        err_next        = err_reg;
        found_next      = found_reg;
        rd_next         = rd_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        chain_ctl.shift = 1'b0;
        chain_ctl.feed  = head;
        status_fin      = ST_DONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next     = '0;
                    op_next    = request.opcode;
                    val_next   = word_t'(request.item_value);
                    pos_next   = request.position;
                    found_next = 1'b0;
                    rd_next    = '0;
                    case (request.opcode)
                        OP_APPEND: err_next = full;
                        OP_QUERY:  err_next = 1'b0;
                        default:   err_next = out_of_range;
                    endcase
                end
            end
            S_RUN:
            begin
                chain_ctl.shift = 1'b1;
                k_next          = k_reg + KW'(1);
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (!err_reg && (k_cmp == count_cmp))
                        begin
                            chain_ctl.feed = val_reg;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!err_reg && (k_cmp >= pos_cmp))
                        begin
                            chain_ctl.feed = second;
                        end
                    end
                    OP_QUERY:
                    begin
                        if ((k_cmp < count_cmp) && (head == val_reg))
                        begin
                            found_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!err_reg && (k_cmp == pos_cmp))
                        begin
                            rd_next = head;
                        end
                    end
                endcase

                if (last_step)
                begin
                    done_next = 1'b1;
                    case (op_reg)
                        OP_APPEND:
                        begin
                            status_fin = err_reg ? ST_FULL : ST_DONE;
                            if (!err_reg)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            status_fin = err_reg ? ST_RANGE : ST_DONE;
                            if (!err_reg)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_QUERY:  status_fin = found_next ? ST_DONE : ST_MISSING;
                        default:   status_fin = err_reg ? ST_RANGE : ST_DONE;
                    endcase
                    res_next.status      = status_fin;
                    res_next.read_value  = rd_next;
                    res_next.entry_count = COUNT_W'(count_next);
                end
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        err_reg   <= err_next;
        found_reg <= found_next;
        rd_reg    <= rd_next;
        res_reg   <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = done_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while sequencer running");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start a rotation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= DEPTH_CMP)
        else $error("entry count beyond depth");

    a_count_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> result_valid)
        else $error("entry count changed without a result");

    a_read_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_DONE)) |-> (result.read_value == '0))
        else $error("nonzero read value on failed command");
`endif

endmodule

/* hdl/sequential_list_table.sv */
// the result and its strobe are registered from the last rotation step
// one command is in flight at a time; each takes one full rotation of the cell ring
// busy is high during the rotation steps; a new command may be taken in the strobe cycle
// results are strobed for one cycle; the receiver cannot stall
// reset clears the entry count and sets capacity to 16; entry contents are not cleared
// ----------------------------------------------------------------------------
// sequential_list_table
// Packed list of signed 32-bit entries held in a ring of cells with append,
// remove at index, membership query and read at index.
// ----------------------------------------------------------------------------
module sequential_list_table #(
    parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  slt_pkg::slt_in_t          request,
    output logic                      result_valid,
    output slt_pkg::slt_out_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [slt_pkg::CAP_W-1:0] cfg_data
);
    import slt_pkg::*;

    slt_chain_ctl_t chain_ctl;
    word_t          cell_q [DEPTH];

    slt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .head         (cell_q[0]),
        .second       (cell_q[1]),
        .chain_ctl    (chain_ctl)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t din;
        if (i == DEPTH - 1)
        begin : g_tail
            assign din = chain_ctl.feed;
        end
        else
        begin : g_body
            assign din = cell_q[i + 1];
        end

        slt_cell u_cell (
            .clk   (clk),
            .shift (chain_ctl.shift),
            .din   (din),
            .q     (cell_q[i])
        );
    end

endmodule

/* verif/slt_checker.sv */
// ----------------------------------------------------------------------------
// slt_checker
// Watches the command, result and capacity channels of the sequential list
// table. Keeps its own copy of the list, works out the outcome of every
// command transfer and compares each result strobe field by field with the
// oldest outcome still due.
// ----------------------------------------------------------------------------
module slt_checker #(
    parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  slt_pkg::slt_in_t          request,
    input  logic                      result_valid,
    input  slt_pkg::slt_out_t         result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [slt_pkg::CAP_W-1:0] cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        checked
);
    import slt_pkg::*;

    word_t    cells [DEPTH];
    int       fill;
    int       capacity;
    slt_out_t outcome_q [$];
    slt_out_t due;

    function automatic slt_out_t list_apply(slt_in_t cmd);
        slt_out_t r;
        int       limit;
        int       i;
        r.status     = ST_DONE;
        r.read_value = '0;
        limit = (capacity > DEPTH) ? DEPTH : capacity;
        case (cmd.opcode)
            OP_APPEND:
            begin
                if (fill >= limit)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    cells[fill] = cmd.item_value;
                    fill++;
                end
            end
            OP_REMOVE:
            begin
                if (int'(cmd.position) >= fill)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (i = int'(cmd.position) + 1; i < fill; i++)
                    begin
                        cells[i-1] = cells[i];
                    end
                    fill--;
                end
            end
            OP_QUERY:
            begin
                r.status = ST_MISSING;
                for (i = 0; i < fill; i++)
                begin
                    if (cells[i] == cmd.item_value)
                    begin
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            default:
            begin
                if (int'(cmd.position) >= fill)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.read_value = cells[cmd.position];
                end
            end
        endcase
        r.entry_count = fill[COUNT_W-1:0];
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        checked = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill     = 0;
            capacity = int'(CAP_RESET);
            outcome_q.delete();
            pending  = 0;
        end
        else
        begin
            // result of the previous command is retired before a new one is taken
            if (result_valid)
            begin
                if (outcome_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: result with nothing due: status %0d value %0d count %0d",
                                 $realtime, result.status, result.read_value,
                                 result.entry_count);
                    end
                    errors++;
                end
                else
                begin
                    due = outcome_q.pop_front();
                    checked++;
                    if (result.status !== due.status ||
                        result.read_value !== due.read_value ||
                        result.entry_count !== due.entry_count)
                    begin
                        if (errors < 10)
                        begin
                            $display({"%0t: result mismatch: status %0d/%0d",
                                      " value %0d/%0d count %0d/%0d (got/exp)"},
                                     $realtime, result.status, due.status,
                                     result.read_value, due.read_value,
                                     result.entry_count, due.entry_count);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                capacity = int'(cfg_data);
            end
            if (start && !busy)
            begin
                outcome_q.push_back(list_apply(request));
            end
            pending = outcome_q.size();
        end
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Regression bench for the sequential list table. A short directed sequence
// covers the empty list, extreme values, every opcode, full and out-of-range
// reports and a capacity lowered below the count; random phases then run
// fill-heavy and drain-heavy command mixes under several capacity settings
// with random idle bursts. Results are checked by slt_checker.
// ----------------------------------------------------------------------------
module tb;
    import slt_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    slt_in_t          request;
    logic             result_valid;
    slt_out_t         result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    int    errors;
    int    pending;
    int    checked;
    int    sent;
    int    cfg_writes;
    word_t value_pool [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sequential_list_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    slt_checker list_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        #6_000_000;
        $display("sequential_list_table regression: fail");
        $finish;
    end

    task automatic issue(opcode_t op, word_t v, logic [POS_W-1:0] p);
        @(negedge clk);
        start   <= 1'b1;
        request <= slt_in_t'{opcode: op, item_value: v, position: p};
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent++;
        if (op == OP_APPEND)
        begin
            value_pool.push_back(v);
            if (value_pool.size() > 32)
            begin
                void'(value_pool.pop_front());
            end
        end
    endtask

    task automatic pause(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic word_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && value_pool.size() > 0)
        begin
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        end
        else if (r < 6)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    function automatic opcode_t pick_op(bit fill_heavy);
        int r;
        r = $urandom_range(0, 99);
        if (fill_heavy)
        begin
            if (r < 50) return OP_APPEND;
            if (r < 65) return OP_REMOVE;
            if (r < 85) return OP_QUERY;
            return OP_READ;
        end
        if (r < 25) return OP_APPEND;
        if (r < 65) return OP_REMOVE;
        if (r < 85) return OP_QUERY;
        return OP_READ;
    endfunction

    logic [CAP_W-1:0] phase_cap [8];
    int               n;
    bit               idle_on;
    logic [POS_W-1:0] p;

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        sent       = 0;
        cfg_writes = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty list
        issue(OP_QUERY, 32'h0000_0000, 4'd0);
        issue(OP_READ, 32'h0, 4'd0);
        issue(OP_REMOVE, 32'h0, 4'd0);
        // extremes
        issue(OP_APPEND, 32'h7FFF_FFFF, 4'd15);
        issue(OP_APPEND, 32'h8000_0000, 4'd0);
        issue(OP_APPEND, 32'h0000_0000, 4'd0);
        issue(OP_APPEND, 32'hFFFF_FFFF, 4'd0);
        issue(OP_APPEND, 32'hAAAA_AAAA, 4'd0);
        issue(OP_QUERY, 32'h8000_0000, 4'd0);
        issue(OP_QUERY, 32'h5555_5555, 4'd0);
        issue(OP_READ, 32'h0, 4'd4);
        issue(OP_READ, 32'h0, 4'd5);
        issue(OP_READ, 32'h0, 4'd15);
        issue(OP_REMOVE, 32'h0, 4'd0);
        issue(OP_REMOVE, 32'h0, 4'd3);
        issue(OP_READ, 32'h0, 4'd0);
        // capacity zero, then lowered below the count
        set_capacity(5'd0);
        issue(OP_APPEND, 32'h1234_5678, 4'd0);
        set_capacity(5'd2);
        issue(OP_APPEND, 32'h1, 4'd0);
        issue(OP_REMOVE, 32'h0, 4'd0);
        issue(OP_APPEND, 32'h2, 4'd0);
        issue(OP_REMOVE, 32'h0, 4'd1);
        issue(OP_APPEND, 32'h3, 4'd0);

        phase_cap = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd9, 5'd16, 5'd31};
        phase_cap[6] = CAP_W'($urandom_range(0, 31));
        for (int ph = 0; ph < 8; ph++)
        begin
            set_capacity(phase_cap[ph]);
            idle_on = (ph != 7) && (ph % 3 != 2);
            for (int k = 0; k < 200; k++)
            begin
                p = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                 : 4'($urandom_range(0, 15));
                issue(pick_op(ph % 2 == 0 ? ((k / 50) % 2 == 0) : ((k / 50) % 2 == 1)),
                      pick_value(), p);
                if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, 17);
                    pause(n);
                end
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        $display("covered %0d commands over %0d capacity writes, %0d results compared",
                 sent, cfg_writes, checked);
        $display("capacities included zero, one, sixteen and above the table depth");
        if (errors == 0 && pending == 0)
        begin
            $display("sequential_list_table regression: pass");
        end
        else
        begin
            $display("sequential_list_table regression: fail");
        end
        $finish;
    end

endmodule
